// ===== src/seven_segment_scan_shifter_defines.svh =====
// Assertion macros for the seven-segment scan shifter checks
`ifndef SEVEN_SEGMENT_SCAN_SHIFTER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_SHIFTER_DEFINES_SVH

// clocked check, off while reset is asserted
`define SSS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("seven_segment_scan_shifter check failed");

// clocked check that also holds during reset
`define SSS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("seven_segment_scan_shifter reset check failed");

`endif

// ===== src/sss_pkg.sv =====
// Package: shared types, constants and segment decode for the scan shifter
`timescale 1ns / 1ps

package sss_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int DIGIT_SLOTS = 4;
  localparam int VALUE_W     = 4;
  localparam int INTERVAL_W  = 16;
  localparam int IDX_W       = 2;
  localparam int FRAME_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;

  localparam logic [VALUE_W-1:0]    DIGIT0_RST   = 4'd1;
  localparam logic [VALUE_W-1:0]    DIGIT1_RST   = 4'd2;
  localparam logic [VALUE_W-1:0]    DIGIT2_RST   = 4'd3;
  localparam logic [VALUE_W-1:0]    DIGIT3_RST   = 4'd4;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd60;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    logic [DIGIT_SLOTS-1:0][VALUE_W-1:0] digit_value;
    logic [INTERVAL_W-1:0]               refresh_interval;
  } cfg_t;

  function automatic logic [7:0] seg_of(input logic [VALUE_W-1:0] v);
    logic [7:0] s;
    if (v > 4'd9) begin
      s = SEG_BLANK;
    end else begin
      s = SEG_TABLE[v];
    end
    return s;
  endfunction

endpackage

// ===== src/sss_if.sv =====
// Channel interfaces: tick input and pin-level result output
`timescale 1ns / 1ps

interface sss_tick_if;
  logic valid;
  logic ready;
  logic us_tick;

  modport source (output valid, output us_tick, input ready);
  modport sink   (input valid, input us_tick, output ready);
endinterface

interface sss_pin_if;
  logic valid;
  logic ready;
  logic serial_data;
  logic shift_clock;
  logic latch_clock;
  logic busy_res;

  modport source (output valid, output serial_data, output shift_clock,
                  output latch_clock, output busy_res, input ready);
  modport sink   (input valid, input serial_data, input shift_clock,
                  input latch_clock, input busy_res, output ready);
endinterface

// ===== src/sss_cfg_regs.sv =====
// Configuration register file: digit values and refresh interval
`timescale 1ns / 1ps

module sss_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output sss_pkg::cfg_t                      cfg_o
);

  sss_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sss_pkg::REG_DIGIT0:   cfg_d.digit_value[0] = cfg_wdata_i[sss_pkg::VALUE_W-1:0];
        sss_pkg::REG_DIGIT1:   cfg_d.digit_value[1] = cfg_wdata_i[sss_pkg::VALUE_W-1:0];
        sss_pkg::REG_DIGIT2:   cfg_d.digit_value[2] = cfg_wdata_i[sss_pkg::VALUE_W-1:0];
        sss_pkg::REG_DIGIT3:   cfg_d.digit_value[3] = cfg_wdata_i[sss_pkg::VALUE_W-1:0];
        sss_pkg::REG_INTERVAL: cfg_d.refresh_interval = cfg_wdata_i[sss_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_value[0]  <= sss_pkg::DIGIT0_RST;
      cfg_q.digit_value[1]  <= sss_pkg::DIGIT1_RST;
      cfg_q.digit_value[2]  <= sss_pkg::DIGIT2_RST;
      cfg_q.digit_value[3]  <= sss_pkg::DIGIT3_RST;
      cfg_q.refresh_interval <= sss_pkg::INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/sss_frame_build.sv =====
// Frame builder: one-hot digit select byte over decoded segment byte
`timescale 1ns / 1ps

module sss_frame_build (
  input  sss_pkg::cfg_t                     cfg_i,
  input  logic [sss_pkg::IDX_W-1:0]         digit_index_i,
  output logic [sss_pkg::FRAME_W-1:0]       frame_o
);

  logic [sss_pkg::VALUE_W-1:0] value;
  logic [7:0]                  select_byte;

  always_comb begin
    value       = cfg_i.digit_value[digit_index_i];
    select_byte = 8'(8'd1 << digit_index_i);
    frame_o     = {select_byte, sss_pkg::seg_of(value)};
  end

endmodule

// ===== src/sss_sequencer.sv =====
// Pin sequencer: tick counter, frame shifter and registered result stage
`timescale 1ns / 1ps

module sss_sequencer #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [sss_pkg::INTERVAL_W-1:0]    refresh_interval_i,
  input  logic [sss_pkg::FRAME_W-1:0]       frame_i,
  output logic [sss_pkg::IDX_W-1:0]         digit_index_o,
  sss_tick_if.sink                          in_if,
  sss_pin_if.source                         out_if
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  localparam logic [sss_pkg::IDX_W-1:0] LAST_DIGIT = sss_pkg::IDX_W'(DIGIT_COUNT - 1);
  localparam logic [4:0] FRAME_BITS = 5'(sss_pkg::FRAME_W);

  logic [sss_pkg::INTERVAL_W-1:0] ticks_q, ticks_d, ticks_inc;
  logic [sss_pkg::IDX_W-1:0]      digit_index_q, digit_index_d;
  logic [sss_pkg::FRAME_W-1:0]    frame_q, frame_d, frame_cur;
  logic [4:0]                     bits_q, bits_d, bits_cur, bits_next;
  logic [1:0]                     phase_q, phase_d, phase_cur;
  logic                           start;
  logic                           accept;

  logic out_valid_q;
  logic data_q, data_d, sclk_q, sclk_d, latch_q, latch_d, busy_q, busy_d;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    ticks_inc = ticks_q;
    if (in_if.us_tick && (ticks_q != '1)) begin
      ticks_inc = ticks_q + 1'b1;
    end
    start     = (phase_q == PH_IDLE) && (ticks_inc >= refresh_interval_i);
    ticks_d   = start ? '0 : ticks_inc;
    phase_cur = start ? PH_HIGH : phase_q;
    frame_cur = start ? frame_i : frame_q;
    bits_cur  = start ? '0 : bits_q;
    bits_next = bits_cur + 1'b1;

    frame_d       = frame_cur;
    bits_d        = bits_cur;
    phase_d       = phase_cur;
    digit_index_d = digit_index_q;
    data_d        = 1'b0;
    sclk_d        = 1'b0;
    latch_d       = 1'b0;
    busy_d        = 1'b0;

    unique case (phase_cur)
      PH_HIGH: begin
        data_d  = frame_cur[sss_pkg::FRAME_W-1];
        sclk_d  = 1'b1;
        busy_d  = 1'b1;
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        data_d  = frame_cur[sss_pkg::FRAME_W-1];
        busy_d  = 1'b1;
        frame_d = {frame_cur[sss_pkg::FRAME_W-2:0], 1'b0};
        bits_d  = bits_next;
        phase_d = (bits_next >= FRAME_BITS) ? PH_LATCH : PH_HIGH;
      end
      PH_LATCH: begin
        latch_d       = 1'b1;
        busy_d        = 1'b1;
        digit_index_d = (digit_index_q >= LAST_DIGIT) ? '0 : digit_index_q + 1'b1;
        phase_d       = PH_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q       <= '0;
      digit_index_q <= '0;
      frame_q       <= '0;
      bits_q        <= '0;
      phase_q       <= PH_IDLE;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        ticks_q       <= ticks_d;
        digit_index_q <= digit_index_d;
        frame_q       <= frame_d;
        bits_q        <= bits_d;
        phase_q       <= phase_d;
        out_valid_q   <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q  <= data_d;
      sclk_q  <= sclk_d;
      latch_q <= latch_d;
      busy_q  <= busy_d;
    end
  end

  assign digit_index_o      = digit_index_q;
  assign out_if.valid       = out_valid_q;
  assign out_if.serial_data = data_q;
  assign out_if.shift_clock = sclk_q;
  assign out_if.latch_clock = latch_q;
  assign out_if.busy_res    = busy_q;

endmodule

// ===== src/seven_segment_scan_shifter.sv =====
// Top level: multiplexed seven-segment display scan shifter
`timescale 1ns / 1ps

// Usage:
//   in_if  carries one step per transaction; us_tick marks a microsecond.
//   out_if returns one transaction per step with the pin levels serial_data,
//   shift_clock, latch_clock and busy_res.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write digit values (0..3) and the refresh
//   interval (4); write only while no step is outstanding.
// Timing: a step's pin levels appear on out_if in the cycle after the step is
//   taken. Throughput: one step per cycle unless out_if stalls, held by the
//   single result register behind the sequencer state update.
// A frame takes 33 steps: 16 bits at two steps each, then one latch step.
// Reset: digits read 1,2,3,4, interval 60, tick count and digit index zero,
//   sequencer idle, no result pending.
// Stall: while out_if.ready is low and a result waits, in_if.ready drops and
//   the result holds; a new step is taken in the cycle the result leaves.

module seven_segment_scan_shifter #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  sss_tick_if.sink                           in_if,
  sss_pin_if.source                          out_if
);

  sss_pkg::cfg_t                  cfg;
  logic [sss_pkg::IDX_W-1:0]      digit_index;
  logic [sss_pkg::FRAME_W-1:0]    frame;

  sss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sss_frame_build u_frame (
    .cfg_i         (cfg),
    .digit_index_i (digit_index),
    .frame_o       (frame)
  );

  sss_sequencer #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .refresh_interval_i (cfg.refresh_interval),
    .frame_i            (frame),
    .digit_index_o      (digit_index),
    .in_if              (in_if),
    .out_if             (out_if)
  );

endmodule

// ===== src/sss_checker.sv =====
// Port checker for the scan shifter, bound to the top level
`timescale 1ns / 1ps
`include "seven_segment_scan_shifter_defines.svh"

module sss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic serial_data,
  input logic shift_clock,
  input logic latch_clock,
  input logic busy_res
);

  `SSS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid)
  `SSS_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(shift_clock) && $stable(latch_clock) && $stable(serial_data))
  `SSS_ASSERT(a_clocks_exclusive, out_valid && (shift_clock || latch_clock) |-> busy_res && !(shift_clock && latch_clock))
  `SSS_ASSERT(a_idle_quiet, out_valid && !busy_res |-> !serial_data && !shift_clock && !latch_clock)

endmodule

bind seven_segment_scan_shifter sss_checker u_sss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .serial_data (out_if.serial_data),
  .shift_clock (out_if.shift_clock),
  .latch_clock (out_if.latch_clock),
  .busy_res    (out_if.busy_res)
);
